// ----- rtl/bmh_pkg.sv -----
package bmh_pkg;

	localparam int DEFAULT_CAPACITY = 64;

	localparam int KEY_W    = 32;
	localparam int ACT_W    = 3;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef logic signed [KEY_W-1:0] key_t;

	// request codes
	localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_EXTRACT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CHANGE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

endpackage

// ----- rtl/bmh_ram.sv -----
module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-first, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/binary_max_heap_priority_queue.sv -----
// Channel   Direction  Transfer                 Signals
// request   in         start high, busy low     action, index, key
// result    out        done high (one cycle)    status, taken_key, max_key, count
//
// One request at a time; busy stays high from the transfer until the result cycle ends.
// Sift-up moves one level per cycle; sift-down takes a RAM read pair, then one compare per
// child through the single shared comparator. The longest request is a remove of the
// deepest entry: walk to the root, then a full sift-down from the root.
// Reset clears the count and the sequencer; heap RAM contents are not cleared.
// The receiver cannot stall: the result is shown in its one done cycle and then dropped.
module binary_max_heap_priority_queue #(
	parameter int CAPACITY = bmh_pkg::DEFAULT_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bmh_pkg::ACT_W-1:0]     action,
	input  logic [bmh_pkg::IDX_W-1:0]     index,
	input  bmh_pkg::key_t                 key,
	output logic                          done,
	output logic [bmh_pkg::STATUS_W-1:0]  status,
	output bmh_pkg::key_t                 taken_key,
	output bmh_pkg::key_t                 max_key,
	output logic [bmh_pkg::COUNT_W-1:0]   count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int ZW = (CW > bmh_pkg::IDX_W) ? CW : bmh_pkg::IDX_W;
	localparam int XW = AW + 2;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_UP    = 4'd1;
	localparam logic [3:0] S_CHG   = 4'd2;
	localparam logic [3:0] S_RM    = 4'd3;
	localparam logic [3:0] S_SHIFT = 4'd4;
	localparam logic [3:0] S_TAKE  = 4'd5;
	localparam logic [3:0] S_LOAD  = 4'd6;
	localparam logic [3:0] S_DN1   = 4'd7;
	localparam logic [3:0] S_DN2   = 4'd8;
	localparam logic [3:0] S_WR    = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]    state_q, state_nxt;
	logic [CW-1:0] cnt_q, cnt_nxt;
	logic [AW-1:0] pos_q, pos_nxt;
	logic [AW-1:0] best_pos_q;
	bmh_pkg::key_t key_q, best_val_q, taken_q, max_q;
	logic [bmh_pkg::STATUS_W-1:0] status_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
	bmh_pkg::key_t ram_wdata, rd_a, rd_b;

	bmh_pkg::key_t cmp_a, cmp_b;
	logic          cmp_gt;

	logic          accept;
	logic          full, idx_ok;
	logic [AW-1:0] par_pos, par_par, ins_par, last_addr, idx_addr;
	logic [XW-1:0] lc_pos, rc_pos, cnt_x, nlc_pos, nrc_pos;
	logic          lc_ok, rc_ok, take_rc, stay;
	logic [AW-1:0] best_idx;
	bmh_pkg::key_t best_val;

	bmh_ram #(
		.WIDTH(bmh_pkg::KEY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign full      = (cnt_q == CW'(CAPACITY));
	assign idx_ok    = (ZW'(index) < ZW'(cnt_q));
	assign idx_addr  = AW'(index);
	assign ins_par   = (AW'(cnt_q) - AW'(1)) >> 1;
	assign last_addr = AW'(cnt_q - CW'(1));
	assign par_pos   = (pos_q - AW'(1)) >> 1;
	assign par_par   = (par_pos - AW'(1)) >> 1;

	assign cnt_x  = XW'(cnt_q);
	assign lc_pos = {1'b0, pos_q, 1'b1};
	assign rc_pos = lc_pos + XW'(1);
	assign lc_ok  = (lc_pos < cnt_x);
	assign rc_ok  = (rc_pos < cnt_x);

	// the one shared comparator
	always_comb begin
		unique case (state_q)
			S_DN1: begin
				cmp_a = rd_a;
				cmp_b = key_q;
			end
			S_DN2: begin
				cmp_a = rd_b;
				cmp_b = best_val_q;
			end
			default: begin
				cmp_a = key_q;
				cmp_b = rd_a;
			end
		endcase
	end
	assign cmp_gt = (cmp_a > cmp_b);

	assign take_rc  = rc_ok && cmp_gt;
	assign best_idx = take_rc ? AW'(rc_pos) : best_pos_q;
	assign best_val = take_rc ? rd_b : best_val_q;
	assign stay     = (best_idx == pos_q);
	assign nlc_pos  = {1'b0, best_idx, 1'b1};
	assign nrc_pos  = nlc_pos + XW'(1);

	always_comb begin
		state_nxt   = state_q;
		cnt_nxt     = cnt_q;
		pos_nxt     = pos_q;
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = key_q;
		ram_raddr_a = AW'(lc_pos);
		ram_raddr_b = AW'(rc_pos);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_DONE;
					unique case (action)
						bmh_pkg::ACT_INSERT: begin
							if (!full) begin
								pos_nxt     = AW'(cnt_q);
								cnt_nxt     = cnt_q + CW'(1);
								ram_raddr_a = ins_par;
								state_nxt   = (cnt_q == '0) ? S_WR : S_UP;
							end
						end
						bmh_pkg::ACT_EXTRACT: begin
							if (cnt_q != '0) begin
								ram_raddr_a = last_addr;
								cnt_nxt     = cnt_q - CW'(1);
								state_nxt   = S_LOAD;
							end
						end
						bmh_pkg::ACT_CHANGE: begin
							if (idx_ok) begin
								pos_nxt     = idx_addr;
								ram_raddr_a = idx_addr;
								state_nxt   = S_CHG;
							end
						end
						bmh_pkg::ACT_REMOVE: begin
							if (idx_ok) begin
								pos_nxt     = idx_addr;
								ram_raddr_a = idx_addr;
								state_nxt   = S_RM;
							end
						end
						default: begin
							state_nxt = S_DONE;
						end
					endcase
				end
			end
			S_CHG: begin
				if (cmp_gt) begin
					ram_raddr_a = par_pos;
					state_nxt   = (pos_q == '0) ? S_WR : S_UP;
				end else begin
					state_nxt = S_DN1;
				end
			end
			S_UP: begin
				if (cmp_gt) begin
					ram_we      = 1'b1;
					ram_wdata   = rd_a;
					pos_nxt     = par_pos;
					ram_raddr_a = par_par;
					state_nxt   = (par_pos == '0) ? S_WR : S_UP;
				end else begin
					ram_we    = 1'b1;
					state_nxt = S_DONE;
				end
			end
			S_RM: begin
				ram_raddr_a = par_pos;
				state_nxt   = (pos_q == '0) ? S_TAKE : S_SHIFT;
			end
			S_SHIFT: begin
				// ancestors slide down one level, no compare
				ram_we      = 1'b1;
				ram_wdata   = rd_a;
				pos_nxt     = par_pos;
				ram_raddr_a = par_par;
				state_nxt   = (par_pos == '0) ? S_TAKE : S_SHIFT;
			end
			S_TAKE: begin
				ram_raddr_a = last_addr;
				cnt_nxt     = cnt_q - CW'(1);
				state_nxt   = S_LOAD;
			end
			S_LOAD: begin
				pos_nxt     = '0;
				ram_raddr_a = AW'(1);
				ram_raddr_b = AW'(2);
				state_nxt   = (cnt_q == '0) ? S_DONE : S_DN1;
			end
			S_DN1: begin
				state_nxt = S_DN2;
			end
			S_DN2: begin
				ram_we = 1'b1;
				if (stay) begin
					state_nxt = S_DONE;
				end else begin
					ram_wdata   = best_val;
					pos_nxt     = best_idx;
					ram_raddr_a = AW'(nlc_pos);
					ram_raddr_b = AW'(nrc_pos);
					state_nxt   = S_DN1;
				end
			end
			S_WR: begin
				ram_we    = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_nxt;
		// root shadow keeps max_key without a final RAM read
		if (ram_we && (ram_waddr == '0)) begin
			max_q <= ram_wdata;
		end
		if (accept) begin
			key_q <= key;
			case (action) inside
				bmh_pkg::ACT_INSERT: begin
					taken_q  <= '0;
					status_q <= full ? bmh_pkg::ST_FULL : bmh_pkg::ST_OK;
				end
				bmh_pkg::ACT_EXTRACT: begin
					if (cnt_q == '0) begin
						taken_q  <= '0;
						status_q <= bmh_pkg::ST_EMPTY;
					end else begin
						taken_q  <= max_q;
						status_q <= bmh_pkg::ST_OK;
					end
				end
				bmh_pkg::ACT_CHANGE, bmh_pkg::ACT_REMOVE: begin
					taken_q  <= '0;
					status_q <= idx_ok ? bmh_pkg::ST_OK : bmh_pkg::ST_BADIDX;
				end
				default: begin
					taken_q  <= '0;
					status_q <= bmh_pkg::ST_OK;
				end
			endcase
		end
		if (state_q == S_RM) begin
			taken_q <= rd_a;
		end
		if (state_q == S_LOAD) begin
			key_q <= rd_a;
		end
		if (state_q == S_DN1) begin
			if (lc_ok && cmp_gt) begin
				best_val_q <= rd_a;
				best_pos_q <= AW'(lc_pos);
			end else begin
				best_val_q <= key_q;
				best_pos_q <= pos_q;
			end
		end
	end

	assign done      = (state_q == S_DONE);
	assign status    = status_q;
	assign taken_key = taken_q;
	assign max_key   = (cnt_q == '0) ? '0 : max_q;
	assign count     = bmh_pkg::COUNT_W'(cnt_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_write_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) < cnt_q))
		else $error("heap write beyond entries in use");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> $stable(cnt_q))
		else $error("count changed with no request");

	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != bmh_pkg::ST_OK)) |-> (taken_key == '0))
		else $error("rejected request returned a key");

endmodule

// ----- tb/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bmh_pkg::*;

	localparam int CAP          = DEFAULT_CAPACITY;
	localparam int RANDOM_ITEMS = 1350;

	typedef struct {
		logic [STATUS_W-1:0] status;
		key_t                taken;
		key_t                top;
		logic [COUNT_W-1:0]  held;
	} heap_result_t;

	typedef enum {LOAD_FILL, LOAD_DRAIN, LOAD_MIXED} load_mode_t;

	// Shadow heap: updated on each request transfer, yields the result the block must report.
	class heap_scoreboard;
		key_t         slot[CAP];
		int           entries;
		int           errors;
		heap_result_t pending[$];

		function new();
			entries = 0;
			errors  = 0;
		endfunction

		function void swap_slots(int a, int b);
			key_t t;
			t       = slot[a];
			slot[a] = slot[b];
			slot[b] = t;
		endfunction

		function void rise(int pos);
			int up;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (!(slot[up] < slot[pos]))
					break;
				swap_slots(up, pos);
				pos = up;
			end
		endfunction

		function void sink(int pos);
			int best;
			int lc;
			int rc;
			forever begin
				best = pos;
				lc   = 2 * pos + 1;
				rc   = 2 * pos + 2;
				if (lc < entries && slot[lc] > slot[best])
					best = lc;
				if (rc < entries && slot[rc] > slot[best])
					best = rc;
				if (best == pos)
					break;
				swap_slots(pos, best);
				pos = best;
			end
		endfunction

		function key_t pop_root();
			key_t top;
			top     = slot[0];
			entries = entries - 1;
			slot[0] = slot[entries];
			sink(0);
			return top;
		endfunction

		function void note_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx, key_t k);
			heap_result_t r;
			key_t         old;
			int           pos;
			r.status = ST_OK;
			r.taken  = '0;
			case (act)
				ACT_INSERT: begin
					if (entries >= CAP) begin
						r.status = ST_FULL;
					end else begin
						slot[entries] = k;
						entries = entries + 1;
						rise(entries - 1);
					end
				end
				ACT_EXTRACT: begin
					if (entries == 0)
						r.status = ST_EMPTY;
					else
						r.taken = pop_root();
				end
				ACT_CHANGE: begin
					if (int'(idx) >= entries) begin
						r.status = ST_BADIDX;
					end else begin
						old = slot[idx];
						slot[idx] = k;
						if (k > old)
							rise(int'(idx));
						else
							sink(int'(idx));
					end
				end
				ACT_REMOVE: begin
					if (int'(idx) >= entries) begin
						r.status = ST_BADIDX;
					end else begin
						// walk the entry to the root unconditionally, then take it
						pos = int'(idx);
						while (pos > 0) begin
							swap_slots((pos - 1) / 2, pos);
							pos = (pos - 1) / 2;
						end
						r.taken = pop_root();
					end
				end
				default: ;
			endcase
			r.top  = (entries != 0) ? slot[0] : key_t'(0);
			r.held = COUNT_W'(entries);
			pending.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, key_t tk, key_t mk,
				logic [COUNT_W-1:0] cnt);
			heap_result_t e;
			if (pending.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (tk !== e.taken) begin
				$error("taken_key: expected %0d, actual %0d", e.taken, tk);
				errors++;
			end
			if (mk !== e.top) begin
				$error("max_key: expected %0d, actual %0d", e.top, mk);
				errors++;
			end
			if (cnt !== e.held) begin
				$error("count: expected %0d, actual %0d", e.held, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	logic                busy;
	logic [ACT_W-1:0]    action = ACT_PEEK;
	logic [IDX_W-1:0]    index  = '0;
	key_t                key    = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	key_t                taken_key;
	key_t                max_key;
	logic [COUNT_W-1:0]  count;

	heap_scoreboard sb = new();

	binary_max_heap_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.index     (index),
		.key       (key),
		.done      (done),
		.status    (status),
		.taken_key (taken_key),
		.max_key   (max_key),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(status, taken_key, max_key, count);
	end

	function automatic key_t pick_key();
		int v;
		v = $urandom_range(0, 9);
		case (v)
			0: return key_t'(32'h8000_0000);
			1: return key_t'(32'h7fff_ffff);
			2, 3: begin
				// narrow range so equal keys are common
				v = $urandom_range(0, 7);
				return key_t'(v - 4);
			end
			default: return key_t'($urandom);
		endcase
	endfunction

	// Start stays high across back-to-back items; the transfer is seen at the edge with busy low.
	task automatic send_request(input logic [ACT_W-1:0] a, input logic [IDX_W-1:0] i,
			input key_t k);
		start  <= 1'b1;
		action <= a;
		index  <= i;
		key    <= k;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(a, i, k);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			start  <= 1'b0;
			action <= ACT_W'($urandom);
			index  <= IDX_W'($urandom);
			key    <= key_t'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		int               sent;
		int               phase_left;
		int               burst_left;
		int               r;
		int               cnt;
		int               waited;
		int               ins, ext, chg, rem;
		load_mode_t       mode;
		logic [ACT_W-1:0] a;
		logic [IDX_W-1:0] i;
		key_t             k;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-heap errors, key extremes, equal keys, up/down changes, bad index
		send_request(ACT_PEEK,    6'd0,  key_t'(0));
		send_request(ACT_EXTRACT, 6'd0,  key_t'(0));
		send_request(ACT_CHANGE,  6'd0,  key_t'(5));
		send_request(ACT_REMOVE,  6'd0,  key_t'(0));
		send_request(ACT_INSERT,  6'd0,  key_t'(32'h7fff_ffff));
		send_request(ACT_INSERT,  6'd0,  key_t'(32'h8000_0000));
		send_request(ACT_INSERT,  6'd0,  key_t'(0));
		send_request(ACT_INSERT,  6'd63, key_t'(-1));
		send_request(ACT_INSERT,  6'd0,  key_t'(0));
		send_request(ACT_INSERT,  6'd0,  key_t'(5));
		send_request(ACT_PEEK,    6'd0,  key_t'(0));
		send_request(ACT_CHANGE,  6'd5,  key_t'(32'h7fff_ffff));
		send_request(ACT_CHANGE,  6'd0,  key_t'(32'h7fff_ffff));
		send_request(ACT_CHANGE,  6'd0,  key_t'(32'h8000_0000));
		send_request(ACT_CHANGE,  6'd4,  key_t'(100));
		send_request(ACT_REMOVE,  6'd5,  key_t'(0));
		send_request(ACT_REMOVE,  6'd0,  key_t'(0));
		send_request(ACT_REMOVE,  6'd63, key_t'(0));
		send_request(ACT_CHANGE,  6'd20, key_t'(7));
		send_request(3'd5,        6'd1,  key_t'(1));
		send_request(3'd6,        6'd2,  key_t'(2));
		send_request(3'd7,        6'd3,  key_t'(3));
		send_request(ACT_EXTRACT, 6'd0,  key_t'(0));
		send_request(ACT_EXTRACT, 6'd0,  key_t'(0));
		pause(3);

		sent       = 0;
		phase_left = 0;
		burst_left = $urandom_range(1, 16);
		mode       = LOAD_MIXED;
		while (sent < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				mode       = load_mode_t'($urandom_range(0, 2));
				phase_left = $urandom_range(60, 200);
			end
			phase_left--;
			case (mode)
				LOAD_FILL:  begin ins = 75; ext = 83; chg = 91; rem = 96; end
				LOAD_DRAIN: begin ins = 20; ext = 55; chg = 70; rem = 92; end
				default:    begin ins = 40; ext = 60; chg = 78; rem = 92; end
			endcase
			r = $urandom_range(0, 99);
			if (r < ins)
				a = ACT_INSERT;
			else if (r < ext)
				a = ACT_EXTRACT;
			else if (r < chg)
				a = ACT_CHANGE;
			else if (r < rem)
				a = ACT_REMOVE;
			else if ($urandom_range(0, 1) == 0)
				a = ACT_PEEK;
			else
				a = ACT_W'($urandom_range(5, 7));

			cnt = sb.entries;
			if (cnt > 0 && $urandom_range(0, 99) < 85)
				i = IDX_W'($urandom_range(0, cnt - 1));
			else
				i = IDX_W'($urandom_range(0, 63));
			k = pick_key();
			if (a == ACT_CHANGE && int'(i) < cnt && $urandom_range(0, 3) == 0)
				k = sb.slot[i];

			send_request(a, i, k);
			sent++;
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 25));
			end
		end

		pause(1);
		waited = 0;
		while (sb.pending.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- binary_max_heap_priority_queue.f -----
rtl/bmh_pkg.sv
rtl/bmh_ram.sv
rtl/binary_max_heap_priority_queue.sv
tb/testbench.sv
